// ===== src/qrsf_pkg.sv =====
// Package for the quadratic ramp setpoint filter.
// Widths, register indexes and saturation helpers; no dependencies.
package qrsf_pkg;

  localparam int POS_W     = 32;  // position / speed width, signed Q16.16
  localparam int LIM_W     = 31;  // limit register width
  localparam int PER_W     = 16;  // eval period width, Q8.8
  localparam int CFG_IDX_W = 3;
  localparam int EXT_W     = 36;  // internal signed width for speeds and distances

  localparam logic [CFG_IDX_W-1:0] REG_EVAL_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_UP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_DOWN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_UP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DOWN  = 3'd4;

  localparam logic [PER_W-1:0] EVAL_PERIOD_RST = 16'd256;

  // Clamp an unsigned value to 2^31-1
  function automatic logic [LIM_W-1:0] cap31(input logic [63:0] v);
    logic [LIM_W-1:0] res;
    begin
      if (v[63:LIM_W] != '0) res = '1;
      else res = v[LIM_W-1:0];
      return res;
    end
  endfunction

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
    logic signed [POS_W-1:0] res;
    begin
      if (v > $signed({{(EXT_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}}))
        res = {1'b0, {(POS_W-1){1'b1}}};
      else if (v < $signed({{(EXT_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}}))
        res = {1'b1, {(POS_W-1){1'b0}}};
      else
        res = v[POS_W-1:0];
      return res;
    end
  endfunction

endpackage

// ===== src/qrsf_if.sv =====
// Channel interfaces for the quadratic ramp setpoint filter.
// Depends on qrsf_pkg for field widths.
interface qrsf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [qrsf_pkg::POS_W-1:0]   target_position;
  modport source (output valid, output target_position, input ready);
  modport sink (input valid, input target_position, output ready);
endinterface

interface qrsf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qrsf_pkg::POS_W-1:0]   ramped_position;
  logic signed [qrsf_pkg::POS_W-1:0]   step_speed;
  logic                                finished;
  modport source (output valid, output ramped_position, output step_speed,
                  output finished, input ready);
  modport sink (input valid, input ramped_position, input step_speed,
                input finished, output ready);
endinterface

interface qrsf_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [qrsf_pkg::CFG_IDX_W-1:0]        index;
  logic [31:0]                           data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/quadratic_ramp_setpoint_filter.sv =====
// Quadratic ramp setpoint filter: speed/accel limited tracking of a target.
// Depends on qrsf_pkg and the channel interfaces in qrsf_if.sv.
//
//  channel    dir  payload                                        transaction
//  in_chan    in   target_position                                valid & ready
//  out_chan   out  ramped_position, step_speed, finished          valid & ready
//  cfg_chan   in   index, data                                    valid & ready
//
// Only an item with a deceleration ramp runs the square root;
// that root takes 32 steps and retires one result bit a cycle.
// One shared 32x32 multiplier forms the scaled limits and the root radicand.
// Synchronous active-low reset clears the state and restores reset limits.
// in_chan takes one item at a time; a finished result waits in the output
// register, and the next item's commit stalls only while that slot is full and unread.
module quadratic_ramp_setpoint_filter (
  input logic         clk,
  input logic         rst_n,
  qrsf_in_if.sink     in_chan,
  qrsf_out_if.source  out_chan,
  qrsf_cfg_if.sink    cfg_chan
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_VP, S_MUL_VN, S_MUL_P2, S_MUL_AP, S_MUL_AN, S_RAMP_SEL,
    S_MUL_Q, S_MUL_P, S_SQRT, S_RAMP_APPLY, S_ACCEL, S_OUT
  } state_t;

  localparam int EW = qrsf_pkg::EXT_W;
  localparam int PW = qrsf_pkg::POS_W;
  localparam int LW = qrsf_pkg::LIM_W;

  state_t state_r;

  // configuration
  logic [qrsf_pkg::PER_W-1:0] eval_period_r;
  logic [LW-1:0] speed_up_r, speed_down_r, accel_up_r, accel_down_r;

  // filter state
  logic signed [PW-1:0] last_output_r, last_speed_r, last_target_r;

  // working registers
  logic signed [EW-1:0] d_r, vp_r, vn_r;
  logic [31:0]          p2_r, m_r;
  logic [LW-1:0]        ap_r, an_r, a_r;
  logic                 ramp_up_r;
  logic [63:0]          q_r, rad_r, root_r, bit_r;

  // output register
  logic                 out_valid_r, out_fin_r;
  logic signed [PW-1:0] out_pos_r, out_spd_r;

  assign cfg_chan.ready  = 1'b1;
  assign in_chan.ready   = (state_r == S_IDLE);
  assign out_chan.valid  = out_valid_r;
  assign out_chan.ramped_position = out_pos_r;
  assign out_chan.step_speed      = out_spd_r;
  assign out_chan.finished        = out_fin_r;

  // shared multiplier operand select
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL_VP: begin mul_a = {1'b0, speed_up_r};   mul_b = {16'd0, eval_period_r}; end
      S_MUL_VN: begin mul_a = {1'b0, speed_down_r}; mul_b = {16'd0, eval_period_r}; end
      S_MUL_P2: begin mul_a = {16'd0, eval_period_r}; mul_b = {16'd0, eval_period_r}; end
      S_MUL_AP: begin mul_a = {1'b0, accel_up_r};   mul_b = p2_r; end
      S_MUL_AN: begin mul_a = {1'b0, accel_down_r}; mul_b = p2_r; end
      S_MUL_Q:  begin mul_a = {1'b0, a_r};          mul_b = {1'b0, a_r}; end
      S_MUL_P:  begin mul_a = {1'b0, a_r};          mul_b = m_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // radicand: q + 2*m*a, saturated at 2^64-1
  logic [64:0] rad_sum;
  assign rad_sum = {1'b0, q_r} + {mul_p, 1'b0};

  // one square-root step
  logic [63:0] trial;
  logic        take;
  assign trial = root_r + bit_r;
  assign take  = (rad_r >= trial);

  // deceleration ramp candidate
  logic signed [EW-1:0] root_s, half_a, ramp_val;
  assign root_s   = $signed(root_r[EW-1:0]);
  assign half_a   = $signed({{(EW-LW+1){1'b0}}, a_r[LW-1:1]});
  assign ramp_val = ramp_up_r ? (root_s - half_a) : (-root_s - half_a);

  // distance magnitude for a downward ramp
  logic signed [EW-1:0] d_neg;
  assign d_neg = -d_r;

  // acceleration bound
  logic signed [EW-1:0] v_ext, ap_ext, an_ext, vp_acc, vn_acc;
  assign v_ext  = EW'(last_speed_r);
  assign ap_ext = $signed({{(EW-LW){1'b0}}, ap_r});
  assign an_ext = $signed({{(EW-LW){1'b0}}, an_r});
  always_comb begin
    vp_acc = vp_r;
    if (v_ext < vp_r) begin
      if (ap_r != '0 && (vp_r - v_ext) > ap_ext) vp_acc = v_ext + ap_ext;
    end else if (v_ext > vp_r) begin
      if (an_r != '0 && (vp_r - v_ext) < -an_ext) vp_acc = v_ext - an_ext;
    end
    vn_acc = vn_r;
    if (v_ext > vn_r) begin
      if (an_r != '0 && (vn_r - v_ext) < -an_ext) vn_acc = v_ext - an_ext;
    end else if (v_ext < vn_r) begin
      if (ap_r != '0 && (vn_r - v_ext) > ap_ext) vn_acc = v_ext + ap_ext;
    end
  end

  // step choice and commit values
  logic signed [EW-1:0] step;
  logic signed [PW-1:0] new_pos, new_spd;
  always_comb begin
    if (d_r > vp_r) step = vp_r;
    else if (d_r < vn_r) step = vn_r;
    else step = d_r;
  end
  assign new_pos = qrsf_pkg::sat32(EW'(last_output_r) + step);
  assign new_spd = qrsf_pkg::sat32(step);

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_period_r <= qrsf_pkg::EVAL_PERIOD_RST;
      speed_up_r    <= '0;
      speed_down_r  <= '0;
      accel_up_r    <= '0;
      accel_down_r  <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        qrsf_pkg::REG_EVAL_PERIOD: eval_period_r <= cfg_chan.data[qrsf_pkg::PER_W-1:0];
        qrsf_pkg::REG_SPEED_UP:    speed_up_r    <= cfg_chan.data[LW-1:0];
        qrsf_pkg::REG_SPEED_DOWN:  speed_down_r  <= cfg_chan.data[LW-1:0];
        qrsf_pkg::REG_ACCEL_UP:    accel_up_r    <= cfg_chan.data[LW-1:0];
        qrsf_pkg::REG_ACCEL_DOWN:  accel_down_r  <= cfg_chan.data[LW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      last_output_r <= '0;
      last_speed_r  <= '0;
      last_target_r <= '0;
    end else begin
      // output slot: loaded on commit, freed by a transaction
      if (state_r == S_OUT && (!out_valid_r || out_chan.ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            last_target_r <= in_chan.target_position;
            d_r     <= EW'(in_chan.target_position) - EW'(last_output_r);
            state_r <= S_MUL_VP;
          end
        end
        S_MUL_VP: begin
          vp_r    <= $signed({{(EW-LW){1'b0}}, qrsf_pkg::cap31({8'd0, mul_p[63:8]})});
          state_r <= S_MUL_VN;
        end
        S_MUL_VN: begin
          vn_r    <= -$signed({{(EW-LW){1'b0}}, qrsf_pkg::cap31({8'd0, mul_p[63:8]})});
          state_r <= S_MUL_P2;
        end
        S_MUL_P2: begin
          p2_r    <= mul_p[31:0];
          state_r <= S_MUL_AP;
        end
        S_MUL_AP: begin
          ap_r    <= qrsf_pkg::cap31({16'd0, mul_p[63:16]});
          state_r <= S_MUL_AN;
        end
        S_MUL_AN: begin
          an_r    <= qrsf_pkg::cap31({16'd0, mul_p[63:16]});
          state_r <= S_RAMP_SEL;
        end
        S_RAMP_SEL: begin
          if (d_r > 0 && an_r != '0) begin
            a_r <= an_r; m_r <= d_r[31:0]; ramp_up_r <= 1'b1;
            state_r <= S_MUL_Q;
          end else if (d_r < 0 && ap_r != '0) begin
            a_r <= ap_r; m_r <= d_neg[31:0]; ramp_up_r <= 1'b0;
            state_r <= S_MUL_Q;
          end else begin
            state_r <= S_ACCEL;
          end
        end
        S_MUL_Q: begin
          q_r     <= {2'b00, mul_p[63:2]};
          state_r <= S_MUL_P;
        end
        S_MUL_P: begin
          rad_r   <= rad_sum[64] ? '1 : rad_sum[63:0];
          root_r  <= '0;
          bit_r   <= 64'd1 << 62;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (take) begin
            rad_r  <= rad_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 64'd1) state_r <= S_RAMP_APPLY;
        end
        S_RAMP_APPLY: begin
          if (ramp_up_r) begin
            if (ramp_val < vp_r) vp_r <= ramp_val;
          end else begin
            if (ramp_val > vn_r) vn_r <= ramp_val;
          end
          state_r <= S_ACCEL;
        end
        S_ACCEL: begin
          vp_r    <= vp_acc;
          vn_r    <= vn_acc;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // commit only when the output slot is free
          if (!out_valid_r || out_chan.ready) begin
            last_output_r <= new_pos;
            last_speed_r  <= new_spd;
            out_pos_r     <= new_pos;
            out_spd_r     <= new_spd;
            out_fin_r     <= (new_pos == last_target_r) && (new_spd == '0);
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a new item always starts the multiply sequence
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == S_MUL_VP))
    else $error("item accepted but sequencer did not start");

  // a finished result never carries motion
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fin_r) |-> (out_spd_r == '0))
    else $error("finished flag with nonzero speed");

  // square-root bit stays a single bit while iterating
  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> $onehot(bit_r))
    else $error("square root bit lost");

  // results are loaded only by the commit state
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result appeared outside commit");

endmodule
